>>> hdl/lca_pkg.sv
// Shared types and constants for the life grid block.
// No dependencies; imported by lca_cell_rule and life_cellular_automaton_grid.
package lca_pkg;

  localparam int IDX_W       = 6;
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int NCNT_W      = 4;

  localparam logic [NCNT_W-1:0] SURVIVE_LOW = NCNT_W'(2);
  localparam logic [NCNT_W-1:0] BIRTH_COUNT = NCNT_W'(3);

  typedef enum logic [IN_TUSER_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_STEP  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // One 3x3 neighborhood; each column holds {below, center, above}.
  typedef struct packed {
    logic [2:0] left;
    logic [2:0] mid;
    logic [2:0] right;
  } win_t;

endpackage

>>> hdl/life_cellular_automaton_grid.sv
// Top level of the life grid: row-wide cell memory, sweep sequencer, output register.
// Depends on lca_pkg and lca_cell_rule.
//
// Usage: one input channel (in_*) carries commands, one output channel (out_*)
// carries read results. in_tuser selects write cell, advance generation, or read
// cell; unused codes and out-of-grid writes are dropped. Only a read makes an
// output beat; a read outside the grid returns dead.
// Cells are stored one grid row per memory word. A write is a read-modify-write
// of its row, and a read can be held by an output stall.
// A generation sweeps the grid one row at a time:
// the neighbor unit handles one cell per cycle out of a three-row window, and
// each finished row is written back over its old copy, which is no longer needed.
// in_tready is low while a command is in progress.
// After reset the memory is cleared one row per cycle, with
// in_tready low. The result waits in an output register; while out_tready is low
// the block keeps taking writes and steps, and a further read waits for the slot.
module life_cellular_automaton_grid
  import lca_pkg::*;
#(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // row[5:0], col[11:6], new_value[12]
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // action[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // cell_alive[0]
);

  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int COL_W = $clog2(GRID_COLS);

  typedef enum logic [9:0] {
    ST_CLEAR   = 10'b0000000001,
    ST_IDLE    = 10'b0000000010,
    ST_WR_MOD  = 10'b0000000100,
    ST_RD_OUT  = 10'b0000001000,
    ST_LD_CUR  = 10'b0000010000,
    ST_LD_NXT  = 10'b0000100000,
    ST_CELL    = 10'b0001000000,
    ST_ROW_END = 10'b0010000000,
    ST_SPARE0  = 10'b0100000000,
    ST_SPARE1  = 10'b1000000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [ROW_W-1:0]     cnt_row_r, cnt_row_nxt;
  logic [COL_W-1:0]     cnt_col_r, cnt_col_nxt;
  logic [ROW_W-1:0]     row_addr_r, row_addr_nxt;
  logic [COL_W-1:0]     col_idx_r, col_idx_nxt;
  logic                 val_r, val_nxt;
  logic                 inside_r, inside_nxt;
  logic [GRID_COLS-1:0] row_p_r, row_p_nxt;
  logic [GRID_COLS-1:0] row_c_r, row_c_nxt;
  logic [GRID_COLS-1:0] row_n_r, row_n_nxt;
  logic [GRID_COLS-1:0] new_row_r, new_row_nxt;
  logic [2:0]           left_r, left_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_alive_r, out_alive_nxt;

  logic [GRID_COLS-1:0] mem [GRID_ROWS];
  logic [GRID_COLS-1:0] rd_data_r;
  logic                 rd_en, wr_en;
  logic [ROW_W-1:0]     rd_addr, wr_addr;
  logic [GRID_COLS-1:0] wr_data;

  logic [IDX_W-1:0] in_row, in_col;
  logic             in_val;
  logic [31:0]      row_ext, col_ext;
  logic             in_inside;
  logic             in_acc;
  action_t          in_action;
  logic             more_rows;
  logic             last_col;
  win_t             win;
  logic             cell_nxt;

  assign in_row    = in_tdata[5:0];
  assign in_col    = in_tdata[11:6];
  assign in_val    = in_tdata[12];
  assign in_action = action_t'(in_tuser);
  assign row_ext   = 32'(in_row);
  assign col_ext   = 32'(in_col);
  assign in_inside = (row_ext < 32'(GRID_ROWS)) && (col_ext < 32'(GRID_COLS));

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_alive_r};

  assign more_rows = (32'(cnt_row_r) + 32'd2) < 32'(GRID_ROWS);
  assign last_col  = (cnt_col_r == COL_W'(GRID_COLS - 1));

  assign win.left  = left_r;
  assign win.mid   = {row_n_r[0], row_c_r[0], row_p_r[0]};
  assign win.right = last_col ? 3'b000 : {row_n_r[1], row_c_r[1], row_p_r[1]};

  lca_cell_rule u_rule (
    .win   (win),
    .alive (cell_nxt)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_row_nxt   = cnt_row_r;
    cnt_col_nxt   = cnt_col_r;
    row_addr_nxt  = row_addr_r;
    col_idx_nxt   = col_idx_r;
    val_nxt       = val_r;
    inside_nxt    = inside_r;
    row_p_nxt     = row_p_r;
    row_c_nxt     = row_c_r;
    row_n_nxt     = row_n_r;
    new_row_nxt   = new_row_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r;
    out_alive_nxt = out_alive_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = cnt_row_r;
    wr_data       = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_row_r;
        if (cnt_row_r == ROW_W'(GRID_ROWS - 1)) begin
          cnt_row_nxt = '0;
          state_nxt   = ST_IDLE;
        end else begin
          cnt_row_nxt = cnt_row_r + ROW_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          row_addr_nxt = in_inside ? row_ext[ROW_W-1:0] : '0;
          col_idx_nxt  = in_inside ? col_ext[COL_W-1:0] : '0;
          val_nxt      = in_val;
          inside_nxt   = in_inside;
          case (in_action)
            ACT_WRITE: begin
              if (in_inside) begin
                rd_en     = 1'b1;
                rd_addr   = row_ext[ROW_W-1:0];
                state_nxt = ST_WR_MOD;
              end
            end
            ACT_STEP: begin
              rd_en       = 1'b1;
              rd_addr     = '0;
              cnt_row_nxt = '0;
              state_nxt   = ST_LD_CUR;
            end
            ACT_READ: begin
              rd_en     = 1'b1;
              rd_addr   = in_inside ? row_ext[ROW_W-1:0] : '0;
              state_nxt = ST_RD_OUT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WR_MOD: begin
        wr_en              = 1'b1;
        wr_addr            = row_addr_r;
        wr_data            = rd_data_r;
        wr_data[col_idx_r] = val_r;
        state_nxt          = ST_IDLE;
      end
      ST_RD_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_alive_nxt = inside_r && rd_data_r[col_idx_r];
          state_nxt     = ST_IDLE;
        end
      end
      ST_LD_CUR: begin
        row_p_nxt = '0;
        row_c_nxt = rd_data_r;
        rd_en     = 1'b1;
        rd_addr   = ROW_W'(1);
        state_nxt = ST_LD_NXT;
      end
      ST_LD_NXT: begin
        row_n_nxt   = rd_data_r;
        cnt_col_nxt = '0;
        left_nxt    = '0;
        state_nxt   = ST_CELL;
      end
      ST_CELL: begin
        new_row_nxt = {cell_nxt, new_row_r[GRID_COLS-1:1]};
        row_p_nxt   = {row_p_r[0], row_p_r[GRID_COLS-1:1]};
        row_c_nxt   = {row_c_r[0], row_c_r[GRID_COLS-1:1]};
        row_n_nxt   = {row_n_r[0], row_n_r[GRID_COLS-1:1]};
        left_nxt    = win.mid;
        if (last_col) begin
          rd_en     = more_rows;
          rd_addr   = ROW_W'(32'(cnt_row_r) + 32'd2);
          state_nxt = ST_ROW_END;
        end else begin
          cnt_col_nxt = cnt_col_r + COL_W'(1);
        end
      end
      ST_ROW_END: begin
        wr_en       = 1'b1;
        wr_addr     = cnt_row_r;
        wr_data     = new_row_r;
        row_p_nxt   = row_c_r;
        row_c_nxt   = row_n_r;
        row_n_nxt   = more_rows ? rd_data_r : '0;
        cnt_col_nxt = '0;
        left_nxt    = '0;
        if (cnt_row_r == ROW_W'(GRID_ROWS - 1)) begin
          cnt_row_nxt = '0;
          state_nxt   = ST_IDLE;
        end else begin
          cnt_row_nxt = cnt_row_r + ROW_W'(1);
          state_nxt   = ST_CELL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_row_r   <= '0;
      cnt_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_row_r   <= cnt_row_nxt;
      cnt_col_r   <= cnt_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_addr_r  <= row_addr_nxt;
    col_idx_r   <= col_idx_nxt;
    val_r       <= val_nxt;
    inside_r    <= inside_nxt;
    row_p_r     <= row_p_nxt;
    row_c_r     <= row_c_nxt;
    row_n_r     <= row_n_nxt;
    new_row_r   <= new_row_nxt;
    left_r      <= left_nxt;
    out_alive_r <= out_alive_nxt;
  end

endmodule

>>> hdl/lca_cell_rule.sv
// Neighbor count and B3/S23 rule for one cell, shared across the whole sweep.
// Depends on lca_pkg (win_t, count constants).
module lca_cell_rule
  import lca_pkg::*;
(
  input  win_t win,
  output logic alive
);

  logic [NCNT_W-1:0] count;

  always_comb begin
    count = NCNT_W'(win.left[0]) + NCNT_W'(win.left[1]) + NCNT_W'(win.left[2])
          + NCNT_W'(win.mid[0]) + NCNT_W'(win.mid[2])
          + NCNT_W'(win.right[0]) + NCNT_W'(win.right[1]) + NCNT_W'(win.right[2]);
    if (win.mid[1]) begin
      alive = (count == SURVIVE_LOW) || (count == BIRTH_COUNT);
    end else begin
      alive = (count == BIRTH_COUNT);
    end
  end

endmodule
